### hdl/kdr_pkg.sv
// kdr_pkg: shared types, register codes and the keypad character table
// for the keypad debounce and repeat block. No dependencies.
`timescale 1ns / 1ps

package kdr_pkg;

  // widths of the fields and registers
  localparam int unsigned KeyCount  = 16;
  localparam int unsigned IdxWidth  = 4;
  localparam int unsigned TickWidth = 16;
  localparam int unsigned CharWidth = 7;
  localparam int unsigned CfgIdxWidth = 2;

  // depth of the queue between front and back
  localparam int unsigned JobDepth = 2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgStableTicks  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgRepeatDelay  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgRepeatPeriod = 2'd2;

  // register values after reset
  localparam logic [TickWidth-1:0] StableTicksRst  = 16'd10;
  localparam logic [TickWidth-1:0] RepeatDelayRst  = 16'd500;
  localparam logic [TickWidth-1:0] RepeatPeriodRst = 16'd33;

  // configuration as seen by the front part
  typedef struct packed {
    logic [TickWidth-1:0] stable_ticks;
    logic [TickWidth-1:0] repeat_delay;
    logic [TickWidth-1:0] repeat_period;
  } cfg_t;

  // one tick's worth of emission work
  typedef struct packed {
    logic [KeyCount-1:0] press_mask;
    logic                rep;
    logic [IdxWidth-1:0] rep_idx;
  } job_t;

  // keypad legend: 123A / 456B / 789C / *0#D
  function automatic logic [CharWidth-1:0] key_char(input logic [IdxWidth-1:0] idx);
    logic [CharWidth-1:0] c;
    case (idx)
      4'd0:    c = 7'h31;
      4'd1:    c = 7'h32;
      4'd2:    c = 7'h33;
      4'd3:    c = 7'h41;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h42;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h38;
      4'd10:   c = 7'h39;
      4'd11:   c = 7'h43;
      4'd12:   c = 7'h2a;
      4'd13:   c = 7'h30;
      4'd14:   c = 7'h23;
      default: c = 7'h44;
    endcase
    return c;
  endfunction

endpackage

### hdl/kdr_front.sv
// kdr_front: per-tick debounce and typematic state; turns an accepted sample
// with new presses or a repeat into a job for the emitter. Depends on kdr_pkg.
`timescale 1ns / 1ps

module kdr_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [kdr_pkg::KeyCount-1:0]        raw_keys_i,
  input  kdr_pkg::cfg_t                       cfg_i,
  output logic                                job_push_o,
  output kdr_pkg::job_t                       job_o
);

  logic                              settling_q, settling_d;
  logic [kdr_pkg::KeyCount-1:0]      watch_q, watch_d;
  logic [kdr_pkg::KeyCount-1:0]      prev_q, prev_d;
  logic [kdr_pkg::TickWidth-1:0]     steady_q, steady_d;
  logic [kdr_pkg::KeyCount-1:0]      pressed_q, pressed_d;
  logic                              held_valid_q, held_valid_d;
  logic [kdr_pkg::IdxWidth-1:0]      held_idx_q, held_idx_d;
  logic [kdr_pkg::TickWidth-1:0]     rpt_cnt_q, rpt_cnt_d;

  logic [kdr_pkg::KeyCount-1:0]      diff;
  logic [kdr_pkg::KeyCount-1:0]      changed;
  logic [kdr_pkg::KeyCount-1:0]      on_mask;
  logic [kdr_pkg::KeyCount-1:0]      off_mask;
  logic [kdr_pkg::TickWidth-1:0]     rpt_dec;
  logic                              fresh;
  logic                              rep;

  // highest set key in a mask
  function automatic logic [kdr_pkg::IdxWidth-1:0] top_idx(
    input logic [kdr_pkg::KeyCount-1:0] m);
    logic [kdr_pkg::IdxWidth-1:0] r;
    r = '0;
    for (int i = 0; i < kdr_pkg::KeyCount; i++) begin
      if (m[i]) r = kdr_pkg::IdxWidth'(i);
    end
    return r;
  endfunction

  assign diff = pressed_q ^ raw_keys_i;

  // settle, accept and repeat decisions for one tick
  always_comb begin
    settling_d   = settling_q;
    watch_d      = watch_q;
    prev_d       = prev_q;
    steady_d     = steady_q;
    pressed_d    = pressed_q;
    held_valid_d = held_valid_q;
    held_idx_d   = held_idx_q;
    rpt_cnt_d    = rpt_cnt_q;
    changed      = '0;
    on_mask      = '0;
    off_mask     = '0;
    rpt_dec      = '0;
    fresh        = 1'b0;
    rep          = 1'b0;
    if (accept_i) begin
      // watch the differing bits
      if (!settling_q) begin
        if (diff != '0) begin
          settling_d = 1'b1;
          watch_d    = diff;
          prev_d     = raw_keys_i;
          steady_d   = '0;
        end
      end else begin
        if (((raw_keys_i ^ prev_q) & watch_q) != '0) begin
          steady_d = '0;
        end else if (steady_q != '1) begin
          steady_d = steady_q + 1'b1;
        end
        prev_d = raw_keys_i;
      end
      // take over the settled changes
      if (settling_d && (steady_d >= cfg_i.stable_ticks)) begin
        changed    = watch_d & diff;
        settling_d = 1'b0;
        if (changed != '0) begin
          on_mask      = changed & raw_keys_i;
          off_mask     = changed & pressed_q;
          held_valid_d = 1'b0;
          if (on_mask != '0) begin
            held_idx_d = top_idx(on_mask);
          end
          if ((on_mask != '0) && (cfg_i.repeat_delay != '0)) begin
            held_valid_d = 1'b1;
            rpt_cnt_d    = cfg_i.repeat_delay;
            fresh        = 1'b1;
          end
          pressed_d = (pressed_q & ~off_mask) | on_mask;
        end
      end
      // typematic countdown, paused while settling
      if (held_valid_d && !fresh && !settling_d) begin
        rpt_dec = (rpt_cnt_d != '0) ? (rpt_cnt_d - 1'b1) : rpt_cnt_d;
        if (rpt_dec == '0) begin
          rep       = 1'b1;
          rpt_cnt_d = (cfg_i.repeat_period != '0) ? cfg_i.repeat_period
                                                  : kdr_pkg::TickWidth'(1);
        end else begin
          rpt_cnt_d = rpt_dec;
        end
      end
    end
  end

  // job towards the emitter
  assign job_o.press_mask = on_mask;
  assign job_o.rep        = rep;
  assign job_o.rep_idx    = held_idx_d;
  assign job_push_o       = accept_i && ((on_mask != '0) || rep);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settling_q   <= 1'b0;
      watch_q      <= '0;
      prev_q       <= '0;
      steady_q     <= '0;
      pressed_q    <= '0;
      held_valid_q <= 1'b0;
      held_idx_q   <= '0;
      rpt_cnt_q    <= '0;
    end else begin
      settling_q   <= settling_d;
      watch_q      <= watch_d;
      prev_q       <= prev_d;
      steady_q     <= steady_d;
      pressed_q    <= pressed_d;
      held_valid_q <= held_valid_d;
      held_idx_q   <= held_idx_d;
      rpt_cnt_q    <= rpt_cnt_d;
    end
  end

`ifndef SYNTH
  // a repeat never shares a tick with new presses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o && job_o.rep |-> job_o.press_mask == '0)
    else $error("repeat issued on a press tick");

  // while settling the watch mask is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    settling_q |-> watch_q != '0)
    else $error("settling with empty watch mask");
`endif

endmodule

### hdl/kdr_job_fifo.sv
// kdr_job_fifo: short queue of emission jobs between front and back.
// Depends on kdr_pkg.
`timescale 1ns / 1ps

module kdr_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kdr_pkg::job_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output kdr_pkg::job_t data_o
);

  localparam int unsigned PtrWidth = (kdr_pkg::JobDepth > 1) ? $clog2(kdr_pkg::JobDepth) : 1;
  localparam int unsigned CntWidth = $clog2(kdr_pkg::JobDepth + 1);

  kdr_pkg::job_t         slots_q [kdr_pkg::JobDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (count_q == CntWidth'(kdr_pkg::JobDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(kdr_pkg::JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(kdr_pkg::JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/kdr_back.sv
// kdr_back: takes jobs; while the output register is empty or popped, emits
// one character a cycle, presses in index order then the repeat. Depends on kdr_pkg.
`timescale 1ns / 1ps

module kdr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  input  kdr_pkg::job_t                      job_i,
  output logic                               job_pop_o,
  output logic                               empty,
  input  logic                               pop,
  output logic [kdr_pkg::CharWidth-1:0]      key_char_o,
  output logic [kdr_pkg::IdxWidth-1:0]       key_index_o,
  output logic                               is_repeat_o,
  output logic                               last_of_run_o
);

  logic                              busy_q, busy_d;
  logic [kdr_pkg::KeyCount-1:0]      rem_q, rem_d;
  logic                              rep_q, rep_d;
  logic [kdr_pkg::IdxWidth-1:0]      rep_idx_q, rep_idx_d;
  logic                              out_valid_q, out_valid_d;
  logic [kdr_pkg::IdxWidth-1:0]      out_idx_q;
  logic                              out_rep_q;
  logic                              out_last_q;

  logic                              advance;
  logic                              emit;
  logic                              has_press;
  logic [kdr_pkg::KeyCount-1:0]      rem_next;
  logic [kdr_pkg::IdxWidth-1:0]      low_idx;
  logic [kdr_pkg::IdxWidth-1:0]      emit_idx;
  logic                              emit_last;
  logic                              done;

  // lowest set key in a mask
  function automatic logic [kdr_pkg::IdxWidth-1:0] low_key(
    input logic [kdr_pkg::KeyCount-1:0] m);
    logic [kdr_pkg::IdxWidth-1:0] r;
    r = '0;
    for (int i = kdr_pkg::KeyCount - 1; i >= 0; i--) begin
      if (m[i]) r = kdr_pkg::IdxWidth'(i);
    end
    return r;
  endfunction

  // pick the next character of the current job
  assign advance   = !out_valid_q || pop;
  assign emit      = busy_q && advance;
  assign has_press = (rem_q != '0);
  assign low_idx   = low_key(rem_q);
  assign rem_next  = rem_q & (rem_q - 1'b1);
  assign emit_idx  = has_press ? low_idx : rep_idx_q;
  assign emit_last = has_press ? ((rem_next == '0) && !rep_q) : 1'b1;
  assign done      = emit && emit_last;
  assign job_pop_o = job_valid_i && (!busy_q || done);

  // job register
  always_comb begin
    busy_d    = busy_q;
    rem_d     = rem_q;
    rep_d     = rep_q;
    rep_idx_d = rep_idx_q;
    if (emit) begin
      if (has_press) begin
        rem_d = rem_next;
      end else begin
        rep_d = 1'b0;
      end
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (job_pop_o) begin
      busy_d    = 1'b1;
      rem_d     = job_i.press_mask;
      rep_d     = job_i.rep;
      rep_idx_d = job_i.rep_idx;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    rep_idx_q <= rep_idx_d;
    if (emit) begin
      out_idx_q  <= emit_idx;
      out_rep_q  <= !has_press;
      out_last_q <= emit_last;
    end
  end

  assign empty         = !out_valid_q;
  assign key_index_o   = out_idx_q;
  assign key_char_o    = kdr_pkg::key_char(out_idx_q);
  assign is_repeat_o   = out_rep_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTH
  // a busy job with no presses left must still owe its repeat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (rem_q == '0) |-> rep_q)
    else $error("empty job left busy");

  // a repeat is always the final character of its tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rep_q |-> out_last_q)
    else $error("repeat not last of run");
`endif

endmodule

### hdl/keypad_debounce_repeat_top.sv
// keypad_debounce_repeat_top: configuration registers and the front,
// job queue and emitter. Depends on kdr_pkg, kdr_front, kdr_job_fifo, kdr_back.
// A tick's first character passes the queue slot, job register and output register.
// Throughput: one sample a cycle while the job queue has room; the emitter
// gives one character a cycle while its output is empty or popped, 1 to 16 a tick.
// Reset: all debounce and repeat state cleared; registers return to 10, 500, 33.
`timescale 1ns / 1ps

module keypad_debounce_repeat_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic [kdr_pkg::KeyCount-1:0]           raw_keys_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [kdr_pkg::CharWidth-1:0]          key_char_o,
  output logic [kdr_pkg::IdxWidth-1:0]           key_index_o,
  output logic                                   is_repeat_o,
  output logic                                   last_of_run_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [kdr_pkg::CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [kdr_pkg::TickWidth-1:0]          cfg_data_i
);

  kdr_pkg::cfg_t cfg_q;
  kdr_pkg::job_t front_job;
  kdr_pkg::job_t queue_job;
  logic          accept;
  logic          job_push;
  logic          queue_full;
  logic          queue_valid;
  logic          queue_pop;

  // configuration transactions
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_ticks  <= kdr_pkg::StableTicksRst;
      cfg_q.repeat_delay  <= kdr_pkg::RepeatDelayRst;
      cfg_q.repeat_period <= kdr_pkg::RepeatPeriodRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kdr_pkg::CfgStableTicks:  cfg_q.stable_ticks  <= cfg_data_i;
        kdr_pkg::CfgRepeatDelay:  cfg_q.repeat_delay  <= cfg_data_i;
        kdr_pkg::CfgRepeatPeriod: cfg_q.repeat_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input side
  assign full   = queue_full;
  assign accept = push && !queue_full;

  kdr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .raw_keys_i (raw_keys_i),
    .cfg_i      (cfg_q),
    .job_push_o (job_push),
    .job_o      (front_job)
  );

  kdr_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (front_job),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (queue_pop),
    .data_o  (queue_job)
  );

  kdr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (queue_valid),
    .job_i         (queue_job),
    .job_pop_o     (queue_pop),
    .empty         (empty),
    .pop           (pop),
    .key_char_o    (key_char_o),
    .key_index_o   (key_index_o),
    .is_repeat_o   (is_repeat_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
